// ===== rtl/swc_pkg.sv =====
package swc_pkg;

    localparam int NUM_CHOICES = 4;
    localparam int NUM_WREGS   = 4;
    localparam int CHOICE_W    = 2;
    localparam int TOTAL_W     = 34;
    localparam int CFG_IDX_W   = 3;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MUL_B  = 64'h94D049BB133111EB;

    localparam logic [CFG_IDX_W-1:0] REG_DOMAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W0     = 3'd3;

    // one queued word between front and back
    typedef struct packed {
        logic [31:0] salt;
    } t_job;

    // 32x32 partial product used by the sliced 64-bit multiply
    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

endpackage

// ===== rtl/swc_front.sv =====
module swc_front
    import swc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_item_salt,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_job        o_q_job
);
    // two-entry queue
    t_job       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_job   = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_q_pop ? ~r_rp : r_rp;
        n_cnt = 2'(r_cnt + {1'b0, push} - {1'b0, i_q_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_mem[r_wp].salt <= i_item_salt;
    end

endmodule

// ===== rtl/swc_back.sv =====
module swc_back
    import swc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_domain_tag,
    input  logic [63:0]         i_run_seed,
    input  logic [31:0]         i_floor_number,
    input  logic [31:0]         i_weight [NUM_WREGS],
    input  logic                i_q_valid,
    input  t_job                i_q_job,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CHOICE_W-1:0] o_choice,
    output logic                o_none_flag
);
    localparam logic [3:0] S_IDLE = 4'd0, S_XS1 = 4'd1, S_M1 = 4'd2, S_XS2 = 4'd3,
        S_M2 = 4'd4, S_FIN = 4'd5, S_NEXT = 4'd6, S_LIM = 4'd7, S_CHK = 4'd8,
        S_MOD = 4'd9, S_OUT = 4'd10;

    logic [3:0]          r_st;
    logic [1:0]          r_stage;   // seed mix count, 3 means last seed mix or drawing
    logic                r_draw;    // seed done, mixes are stream draws
    logic [1:0]          r_part;    // partial-product slice
    logic [63:0]         r_z, r_acc, r_h, r_stream;
    logic [31:0]         r_salt;
    logic [TOTAL_W-1:0]  r_total;
    logic [63:0]         r_limit, r_rem, r_qt;
    logic [6:0]          r_bit;
    logic                r_lim_mode;
    logic [CHOICE_W-1:0] r_choice;
    logic                r_none;
    logic                r_valid;

    logic [TOTAL_W-1:0] pw [NUM_CHOICES];
    logic [TOTAL_W-1:0] total_c;
    logic [63:0]        mul_k, part;
    logic [31:0]        pa, pb;
    logic [64:0]        rem_sh;
    logic [CHOICE_W-1:0] pick;
    logic               out_fire;

    always_comb begin
        total_c = '0;
        for (int i = 0; i < NUM_CHOICES; i++) begin
            if (i < NUM_WREGS && !i_weight[i][31] && i_weight[i] != 32'd0)
                pw[i] = TOTAL_W'(i_weight[i]);
            else
                pw[i] = '0;
            total_c = total_c + pw[i];
        end
    end

    assign mul_k = (r_st == S_M1) ? MUL_A : MUL_B;
    // low 64 bits from three 32x32 slices: lo*lo, hi*lo, lo*hi
    always_comb begin
        unique case (r_part)
            2'd0:    begin pa = r_z[31:0];  pb = mul_k[31:0];  end
            2'd1:    begin pa = r_z[63:32]; pb = mul_k[31:0];  end
            default: begin pa = r_z[31:0];  pb = mul_k[63:32]; end
        endcase
        part = mul32(pa, pb);
    end

    // restoring divider step, one quotient bit per cycle
    assign rem_sh = r_lim_mode ? {r_rem, 1'b1} : {r_rem, r_qt[63]};

    always_comb begin
        pick = CHOICE_W'(NUM_CHOICES - 1);
        for (int i = NUM_CHOICES - 1; i >= 0; i--) begin
            logic [TOTAL_W-1:0] c;
            c = '0;
            for (int j = 0; j <= i; j++) c = c + pw[j];
            if (pw[i] != '0 && r_rem < 64'(c)) pick = CHOICE_W'(i);
        end
    end

    assign out_fire    = (r_st == S_OUT) && (!r_valid || !i_stall);
    assign o_q_pop     = (r_st == S_IDLE) && i_q_valid;
    assign o_valid     = r_valid;
    assign o_choice    = r_choice;
    assign o_none_flag = r_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (out_fire) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_salt  <= i_q_job.salt;
                    r_total <= total_c;
                    if (total_c == '0) begin
                        r_st <= S_OUT;
                    end else begin
                        r_stage <= 2'd0;
                        r_draw  <= 1'b0;
                        r_z     <= i_domain_tag + GOLDEN;
                        r_st    <= S_XS1;
                    end
                end
                S_XS1: begin
                    r_z <= r_z ^ (r_z >> 30); r_part <= 2'd0; r_acc <= '0; r_st <= S_M1;
                end
                S_M1, S_M2: begin
                    if (r_part == 2'd0) r_acc <= part;
                    else r_acc <= r_acc + {part[31:0], 32'd0};
                    if (r_part == 2'd2) begin
                        r_part <= 2'd0;
                        r_st   <= (r_st == S_M1) ? S_XS2 : S_FIN;
                    end else r_part <= 2'(r_part + 2'd1);
                end
                S_XS2: begin
                    r_z <= r_acc ^ (r_acc >> 27); r_acc <= '0; r_st <= S_M2;
                end
                S_FIN: begin
                    r_h <= r_acc ^ (r_acc >> 31);
                    r_st <= S_NEXT;
                end
                S_NEXT: begin
                    unique case (r_stage)
                        2'd0: r_z <= (r_h ^ i_run_seed) + GOLDEN;
                        2'd1: r_z <= (r_h ^ {32'd0, i_floor_number}) + GOLDEN;
                        2'd2: r_z <= (r_h ^ {32'd0, r_salt}) + GOLDEN;
                        default: begin
                            if (!r_draw) begin
                                // seed just produced: start the stream and the limit
                                r_stream   <= r_h + GOLDEN;
                                r_z        <= r_h + GOLDEN;
                                r_lim_mode <= 1'b1;
                                r_rem      <= '0;
                                r_qt       <= '0;
                                r_bit      <= 7'd64;
                                r_draw     <= 1'b1;
                                r_st       <= S_LIM;
                            end else begin
                                r_st <= S_CHK;
                            end
                        end
                    endcase
                    if (r_stage != 2'd3) begin
                        r_stage <= 2'(r_stage + 2'd1);
                        r_st    <= S_XS1;
                    end
                end
                S_LIM: begin
                    // quotient of all-ones by total, then limit = q * total
                    if (r_bit != 7'd0) begin
                        if (rem_sh >= 65'(r_total)) begin
                            r_rem <= 64'(rem_sh - 65'(r_total));
                            r_qt  <= {r_qt[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[63:0];
                            r_qt  <= {r_qt[62:0], 1'b0};
                        end
                        r_bit <= 7'(r_bit - 7'd1);
                    end else begin
                        r_limit    <= 64'hFFFF_FFFF_FFFF_FFFF - r_rem;
                        r_lim_mode <= 1'b0;
                        r_st       <= S_XS1;
                    end
                end
                S_CHK: begin
                    if (r_h >= r_limit) begin
                        r_stream <= r_stream + GOLDEN;
                        r_z      <= r_stream + GOLDEN;
                        r_st     <= S_XS1;
                    end else begin
                        r_qt  <= r_h;
                        r_rem <= '0;
                        r_bit <= 7'd64;
                        r_st  <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_bit != 7'd0) begin
                        r_qt <= {r_qt[62:0], 1'b0};
                        if (rem_sh >= 65'(r_total)) r_rem <= 64'(rem_sh - 65'(r_total));
                        else r_rem <= rem_sh[63:0];
                        r_bit <= 7'(r_bit - 7'd1);
                    end else r_st <= S_OUT;
                end
                S_OUT: if (out_fire) begin
                    // load the result word only once the previous one has left
                    r_none   <= (r_total == '0);
                    r_choice <= (r_total == '0) ? '0 : pick;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/seeded_weighted_choice_top.sv =====
// channel | valid    | stall    | word
// input   | i_valid  | o_stall  | i_item_salt
// output  | o_valid  | i_stall  | o_choice, o_none_flag
// An item runs from one queue pop to the next through four seed mixes on
// one shared 32x32 multiplier slice, the rejection limit, one more mix per
// draw, the remainder and the load of the result once the output is free.
// Each rejected draw adds another mix. A zero total weight goes straight to the output.
// Reset is synchronous, active low.
// A two-word queue takes input while the back end works or the output stalls.
module seeded_weighted_choice_top
    import swc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_item_salt,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CHOICE_W-1:0]  o_choice,
    output logic                 o_none_flag
);
    logic [63:0] r_domain_tag, r_run_seed;
    logic [31:0] r_floor_number;
    logic [31:0] r_weight [NUM_WREGS];
    logic        q_valid, q_pop;
    t_job        q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain_tag   <= '0;
            r_run_seed     <= '0;
            r_floor_number <= '0;
            for (int i = 0; i < NUM_WREGS; i++) r_weight[i] <= (i == 0) ? 32'd1 : 32'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_DOMAIN) r_domain_tag <= i_cfg_data;
            else if (i_cfg_idx == REG_RUN) r_run_seed <= i_cfg_data;
            else if (i_cfg_idx == REG_FLOOR) r_floor_number <= i_cfg_data[31:0];
            else if (i_cfg_idx >= REG_W0 && 32'(i_cfg_idx) < 32'(REG_W0) + NUM_WREGS)
                r_weight[2'(i_cfg_idx - REG_W0)] <= i_cfg_data[31:0];
        end
    end

    swc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item_salt,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_job(q_job)
    );

    swc_back u_back (
        .i_clk, .i_rst_n,
        .i_domain_tag(r_domain_tag), .i_run_seed(r_run_seed),
        .i_floor_number(r_floor_number), .i_weight(r_weight),
        .i_q_valid(q_valid), .i_q_job(q_job), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_choice, .o_none_flag
    );

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("queue popped while empty");
    a_none_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_flag) |-> (o_choice == '0)) else $error("none with choice");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_choice))) else $error("output dropped");

endmodule

// ===== tb/swc_checker.sv =====
`timescale 1ns / 100ps

module swc_checker
    import swc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  logic [31:0]          i_item_salt,
    input  logic                 i_out_valid,
    input  logic                 i_stall_out,
    input  logic [CHOICE_W-1:0]  i_choice,
    input  logic                 i_none_flag,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic [CHOICE_W-1:0] choice;
        logic                none_flag;
    } t_pick;

    logic [63:0] domain_q;
    logic [63:0] run_q;
    logic [31:0] floor_q;
    logic [31:0] weight_q [NUM_WREGS];
    t_pick       picks_due [$];

    function automatic logic [63:0] splitmix(input logic [63:0] z);
        z = (z ^ (z >> 30)) * MUL_A;
        z = (z ^ (z >> 27)) * MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] live_weight(input int i);
        if (i >= NUM_WREGS || weight_q[i][31] || weight_q[i] == 0) return 64'd0;
        return {32'd0, weight_q[i]};
    endfunction

    function automatic t_pick pick_choice(input logic [31:0] salt);
        logic [63:0] total, seed, limit, draw, rem, acc;
        t_pick       p;
        total = 0;
        acc = 0;
        p = '0;
        for (int i = 0; i < NUM_CHOICES; i++) total += live_weight(i);
        if (total == 0) begin
            p.none_flag = 1'b1;
            return p;
        end
        seed = splitmix(domain_q + GOLDEN);
        seed = splitmix((seed ^ run_q) + GOLDEN);
        seed = splitmix((seed ^ {32'd0, floor_q}) + GOLDEN);
        seed = splitmix((seed ^ {32'd0, salt}) + GOLDEN);
        limit = (64'hFFFF_FFFF_FFFF_FFFF / total) * total;
        do begin
            seed += GOLDEN;
            draw = splitmix(seed);
        end while (draw >= limit);
        rem = draw % total;
        p.choice = CHOICE_W'(NUM_CHOICES - 1);
        for (int i = 0; i < NUM_CHOICES; i++) begin
            if (live_weight(i) != 0) begin
                acc += live_weight(i);
                if (rem < acc) begin
                    p.choice = CHOICE_W'(i);
                    break;
                end
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    assign o_pending = picks_due.size();

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            domain_q <= '0;
            run_q    <= '0;
            floor_q  <= '0;
            weight_q <= '{32'd1, 32'd0, 32'd0, 32'd0};
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DOMAIN: domain_q <= i_cfg_data;
                    REG_RUN:    run_q    <= i_cfg_data;
                    REG_FLOOR:  floor_q  <= i_cfg_data[31:0];
                    default: begin
                        if (i_cfg_idx >= REG_W0 && i_cfg_idx < REG_W0 + NUM_WREGS)
                            weight_q[2'(i_cfg_idx - REG_W0)] <= i_cfg_data[31:0];
                    end
                endcase
            end
            if (i_valid && !i_stall_in) picks_due = {picks_due, pick_choice(i_item_salt)};
            if (i_out_valid && !i_stall_out) begin
                if (picks_due.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = picks_due.pop_front();
                    if (i_choice !== want.choice)
                        report_mismatch($sformatf("choice %0d, want %0d", i_choice, want.choice));
                    if (i_none_flag !== want.none_flag)
                        report_mismatch($sformatf("none_flag %0b, want %0b",
                                                  i_none_flag, want.none_flag));
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import swc_pkg::*;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [63:0]          cfg_data = '0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [31:0]          salt = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    logic [CHOICE_W-1:0]  choice;
    logic                 none_flag;
    int                   errors;
    int                   pending;
    bit                   calm = 0;
    bit                   hold_out = 0;

    seeded_weighted_choice_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_item_salt(salt), .o_valid(out_valid), .i_stall(out_stall),
        .o_choice(choice), .o_none_flag(none_flag)
    );

    swc_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_item_salt(salt), .i_out_valid(out_valid), .i_stall_out(out_stall),
        .i_choice(choice), .i_none_flag(none_flag), .o_errors(errors),
        .o_pending(pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        int n;
        bit held;
        held = 0;
        forever begin
            @(posedge clk);
            if (hold_out && !held) begin
                held = 1;
                out_stall <= 1'b1;
                for (n = 0; n < 3000; n++) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all results, then past any tail of work
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic send_word(input logic [31:0] value);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        salt     <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] any_weight();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return {$urandom, 32'h8000_0000 | $urandom};
            2: return 64'h7FFF_FFFF;
            3: return 64'($urandom_range(1, 3));
            4: return 64'($urandom_range(1, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] any_salt();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] edge_salts [6] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h1, 32'h5555_AAAA};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset weights: only choice 0 live
        foreach (edge_salts[i]) send_word(edge_salts[i]);
        end_burst();
        drain();

        // all weights nonpositive
        write_reg(REG_DOMAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_RUN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_FLOOR, 64'h8000_0000);
        write_reg(REG_W0, 64'h0);
        write_reg(CFG_IDX_W'(REG_W0 + 1), 64'hFFFF_FFFF);
        write_reg(CFG_IDX_W'(REG_W0 + 2), 64'h8000_0000);
        write_reg(CFG_IDX_W'(REG_W0 + 3), 64'h0);
        for (int i = 0; i < 4; i++) send_word(edge_salts[i]);
        end_burst();
        drain();

        // largest weights, one skipped in the middle
        write_reg(REG_FLOOR, 64'h7FFF_FFFF);
        for (int i = 0; i < NUM_WREGS; i++) write_reg(CFG_IDX_W'(REG_W0 + i), 64'h7FFF_FFFF);
        write_reg(CFG_IDX_W'(REG_W0 + 1), 64'hFFFF_FFFF_8000_0000);
        foreach (edge_salts[i]) send_word(edge_salts[i]);
        end_burst();
        drain();

        // small weights, only the last live
        write_reg(REG_DOMAIN, 64'h0);
        write_reg(REG_RUN, 64'h0);
        write_reg(REG_W0, 64'h0);
        write_reg(CFG_IDX_W'(REG_W0 + 1), 64'h0);
        write_reg(CFG_IDX_W'(REG_W0 + 2), 64'hFFFF_FFFF);
        write_reg(CFG_IDX_W'(REG_W0 + 3), 64'd3);
        foreach (edge_salts[i]) send_word(edge_salts[i]);
        end_burst();
        drain();

        // fill the queue while the output holds off
        hold_out = 1;
        for (int i = 0; i < 8; i++) send_word($urandom);
        end_burst();
        drain();

        for (int ph = 0; ph < 35; ph++) begin
            write_reg(REG_DOMAIN, {$urandom, $urandom});
            write_reg(REG_RUN, {$urandom, $urandom});
            write_reg(REG_FLOOR, {$urandom, $urandom});
            for (int i = 0; i < NUM_WREGS; i++) write_reg(CFG_IDX_W'(REG_W0 + i), any_weight());
            if (ph >= 31) calm = 1;
            for (int k = 0; k < 50; k++) send_word(any_salt());
            end_burst();
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
